// ===== rtl/core/hfcp_pkg.sv =====
// shared constants, register indexes and control/status types of the frame parser
package hfcp_pkg;

    localparam int MAX_DATA    = 9;
    localparam int STORE_DEPTH = MAX_DATA + 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int LEN_CW      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hBB;
    localparam logic [BYTE_W-1:0] LONG_COMMAND_RST  = 8'h10;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST     = 8'hFA;
    localparam logic [LEN_W-1:0]  LONG_LENGTH_RST   = 4'd9;
    localparam logic [LEN_W-1:0]  SHORT_LENGTH_RST  = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_FIRST  = 3'd0,
        REG_HEADER_SECOND = 3'd1,
        REG_LONG_COMMAND  = 3'd2,
        REG_TAIL_BYTE     = 3'd3,
        REG_LONG_LENGTH   = 3'd4,
        REG_SHORT_LENGTH  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic in_ready;
        logic wr_cmd;
        logic wr_body;
        logic start_emit;
        logic kind_short;
        logic emit_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hdr1_hit;
        logic hdr2_hit;
        logic long_hit;
        logic long_full;
        logic short_full;
        logic issue_last;
    } dp_status_t;

endpackage

// ===== rtl/core/header_framed_command_parser.sv =====
// top level of the header-framed command parser
//
// input stream: one received byte per transfer, tuser flags an inter-byte timeout,
// which sends the parser back to header hunting before the byte is looked at.
// the parser hunts for two header bytes, takes a command byte, then a fixed
// number of data bytes (long or short frame) and a tail byte.
// while parsing, one byte is taken every cycle.
// on the tail byte tready drops; the command byte and the data bytes are read
// back from a small body store, one per cycle, and sent on the output stream
// with frame kind and tail match in tuser and tlast on the final one.
// a frame with n data bytes gives n+1 results, read through the single read
// port of the body store; tready returns once the last store read is issued,
// and each result passes the store read register and then the output register.
// a stalled receiver holds the output register and pauses the store reads;
// the input side may already resume while the last results drain.
// reset puts the parser into hunting, empties the output and loads the default
// header, command, tail and length registers; the user must write config through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module header_framed_command_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hfcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hfcp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // rx_byte
    input  logic                            s_axis_tuser,  // timed_out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // out_byte
    output logic [1:0]                      m_axis_tuser,  // frame_kind in bit 0, tail_ok in bit 1
    output logic                            m_axis_tlast
);
    import hfcp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    hfcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .timed_out (s_axis_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    hfcp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_byte   (m_axis_tdata),
        .frame_kind (m_axis_tuser[0]),
        .tail_ok    (m_axis_tuser[1]),
        .last       (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule

// ===== rtl/core/hfcp_ram.sv =====
// generic simple dual-port ram with registered read
module hfcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hfcp_ctrl.sv =====
// frame parser controller: header hunt, command, body and emission sequencing
module hfcp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               timed_out,
    input  hfcp_pkg::dp_status_t status,
    output hfcp_pkg::ctrl_cmd_t  cmd
);
    import hfcp_pkg::*;

    typedef enum logic [2:0] {
        S_HUNT1,
        S_HUNT2,
        S_CMD,
        S_LONG,
        S_SHORT,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t eff_state;
    logic   in_fire;
    logic   full;

    assign in_fire   = in_valid && (state_reg != S_EMIT);
    assign eff_state = timed_out ? S_HUNT1 : state_reg;
    assign full      = (eff_state == S_LONG) ? status.long_full : status.short_full;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.in_ready   = (state_reg != S_EMIT);
        cmd.emit_en    = (state_reg == S_EMIT);
        cmd.kind_short = (eff_state == S_SHORT);
        if (state_reg == S_EMIT)
        begin
            if (status.issue_last)
            begin
                state_next = S_HUNT1;
            end
        end
        else if (in_fire)
        begin
            case (eff_state)
                S_HUNT2:
                begin
                    if (status.hdr2_hit)
                        state_next = S_CMD;
                    else if (status.hdr1_hit)
                        state_next = S_HUNT2;
                    else
                        state_next = S_HUNT1;
                end
                S_CMD:
                begin
                    cmd.wr_cmd = 1'b1;
                    state_next = status.long_hit ? S_LONG : S_SHORT;
                end
                S_LONG, S_SHORT:
                begin
                    if (full)
                    begin
                        cmd.start_emit = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        cmd.wr_body = 1'b1;
                        state_next  = eff_state;
                    end
                end
                default:
                begin
                    state_next = status.hdr1_hit ? S_HUNT2 : S_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/hfcp_dp.sv =====
// frame parser datapath: config registers, body store, read pipeline and output register
module hfcp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hfcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hfcp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [hfcp_pkg::BYTE_W-1:0]       rx_byte,
    input  hfcp_pkg::ctrl_cmd_t               cmd,
    output hfcp_pkg::dp_status_t              status,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [hfcp_pkg::BYTE_W-1:0]       out_byte,
    output logic                              frame_kind,
    output logic                              tail_ok,
    output logic                              last
);
    import hfcp_pkg::*;

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] long_command_reg;
    logic [BYTE_W-1:0] tail_byte_reg;
    logic [LEN_W-1:0]  long_length_reg;
    logic [LEN_W-1:0]  short_length_reg;

    logic [CNT_W-1:0]  body_count_reg, body_count_next;
    logic [CNT_W-1:0]  emit_idx_reg, emit_idx_next;
    logic              kind_reg, ok_reg;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_kind_reg, rd_ok_reg, rd_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_kind_reg, out_ok_reg, out_last_reg;

    logic [LEN_CW-1:0] long_len_c, short_len_c, count_ext;
    logic              move, issue, idx_last;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] rd_data;

    // lengths saturate at MAX_DATA, the store size less the command slot
    assign long_len_c  = (LEN_CW'(long_length_reg) > LEN_CW'(MAX_DATA)) ?
                         LEN_CW'(MAX_DATA) : LEN_CW'(long_length_reg);
    assign short_len_c = (LEN_CW'(short_length_reg) > LEN_CW'(MAX_DATA)) ?
                         LEN_CW'(MAX_DATA) : LEN_CW'(short_length_reg);
    assign count_ext   = LEN_CW'(body_count_reg);

    assign status.hdr1_hit   = (rx_byte == header_first_reg);
    assign status.hdr2_hit   = (rx_byte == header_second_reg);
    assign status.long_hit   = (rx_byte == long_command_reg);
    assign status.long_full  = (count_ext >= long_len_c);
    assign status.short_full = (count_ext >= short_len_c);

    assign move     = rd_pend_reg && (!out_valid_reg || out_ready);
    assign issue    = cmd.emit_en && (!rd_pend_reg || move);
    assign idx_last = (emit_idx_reg == body_count_reg);
    assign status.issue_last = issue && idx_last;

    assign wr_en   = cmd.wr_cmd || cmd.wr_body;
    assign wr_addr = cmd.wr_cmd ? '0 : CNT_W'(body_count_reg + 1'b1);

    hfcp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (issue),
        .rd_addr (emit_idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        body_count_next = body_count_reg;
        if (cmd.wr_cmd)
            body_count_next = '0;
        else if (cmd.wr_body)
            body_count_next = CNT_W'(body_count_reg + 1'b1);

        emit_idx_next = emit_idx_reg;
        if (cmd.start_emit)
            emit_idx_next = '0;
        else if (issue)
            emit_idx_next = CNT_W'(emit_idx_reg + 1'b1);

        rd_pend_next = issue ? 1'b1 : (move ? 1'b0 : rd_pend_reg);
        out_valid_next = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            long_command_reg  <= LONG_COMMAND_RST;
            tail_byte_reg     <= TAIL_BYTE_RST;
            long_length_reg   <= LONG_LENGTH_RST;
            short_length_reg  <= SHORT_LENGTH_RST;
            body_count_reg    <= '0;
            emit_idx_reg      <= '0;
            rd_pend_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                    REG_HEADER_SECOND: header_second_reg <= cfg_data;
                    REG_LONG_COMMAND:  long_command_reg  <= cfg_data;
                    REG_TAIL_BYTE:     tail_byte_reg     <= cfg_data;
                    REG_LONG_LENGTH:   long_length_reg   <= cfg_data[LEN_W-1:0];
                    REG_SHORT_LENGTH:  short_length_reg  <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            body_count_reg <= body_count_next;
            emit_idx_reg   <= emit_idx_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_emit)
        begin
            kind_reg <= cmd.kind_short;
            ok_reg   <= (rx_byte == tail_byte_reg);
        end
        if (issue)
        begin
            rd_kind_reg <= kind_reg;
            rd_ok_reg   <= ok_reg;
            rd_last_reg <= idx_last;
        end
        if (move)
        begin
            out_byte_reg <= rd_data;
            out_kind_reg <= rd_kind_reg;
            out_ok_reg   <= rd_ok_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_kind = out_kind_reg;
    assign tail_ok    = out_ok_reg;
    assign last       = out_last_reg;

endmodule

// ===== rtl/core/hfcp_checker.sv =====
// port-level checker for the frame parser and its bind
module hfcp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("output payload changed while stalled");

    // tags stay constant across the results of one frame
    a_frame_tags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (!m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser))))
        else $error("frame tags changed within a frame");

    // input side only closes after an accepted byte
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without a transfer");

    // nothing is offered on the output and the input stays ready during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> (!m_axis_tvalid && s_axis_tready))
        else $error("output valid or input stall during reset");

endmodule

bind header_framed_command_parser hfcp_checker u_hfcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
